FILE: rtl/ghi_pkg.sv
// Shared types and constants for the gyro heading integrator.
`timescale 1ns / 1ps
package ghi_pkg;

	// Reset value of the calibration sample count.
	localparam logic [15:0] CAL_COUNT_RESET = 16'd5120;

	// The scale factor 14680064 / 17578125 is applied as a multiplication by
	// ceil(2^56 * 14680064 / 17578125) and a right shift by 56. This is exact for every
	// product of a 16-bit rate magnitude and a 16-bit time step. The 56-bit reciprocal
	// is split into two 28-bit halves.
	localparam logic [27:0] SCALE_RECIP_HI = 28'd224179181;
	localparam logic [27:0] SCALE_RECIP_LO = 28'd121153339;

	// Degrees in a full turn, for the heading conversion.
	localparam logic signed [9:0] DEG_FULL = 10'sd360;

	// Request codes carried in the input tuser field.
	typedef enum logic [1:0] {
		REQ_ZERO = 2'd0,
		REQ_CAL  = 2'd1,
		REQ_UPD  = 2'd2,
		REQ_NONE = 2'd3
	} ghi_req_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CAL,
		ST_UPD,
		ST_MLO,
		ST_MHI,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} ghi_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic cal_step;
		logic upd_step;
		logic mul_lo;
		logic mul_hi;
		logic div_step;
		logic finish;
		logic out_load;
	} ghi_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cal_hit;
		logic div_done;
		logic out_free;
	} ghi_status_t;

endpackage

FILE: rtl/ghi_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle while step is high, 32 steps.
`timescale 1ns / 1ps
module ghi_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic        step,
	input  logic [24:0] rem_init,
	input  logic [31:0] dividend,
	input  logic [24:0] divisor,
	output logic [31:0] quotient,
	output logic        done
);

	logic [24:0] rem_q;
	logic [31:0] quo_q;
	logic [24:0] dvs_q;
	logic [4:0]  cnt_q;
	logic [25:0] trial;
	logic        fits;
	logic [24:0] rem_nxt;

	// Shift in the next dividend bit and try to subtract the divisor.
	always_comb begin
		trial   = {rem_q, quo_q[31]};
		fits    = trial >= {1'b0, dvs_q};
		rem_nxt = fits ? 25'(trial - {1'b0, dvs_q}) : trial[24:0];
	end

	// Remainder, dividend/quotient shift register and divisor.
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= rem_init;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (step) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[30:0], fits};
		end
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 5'd1;
		end
	end

	assign done     = (cnt_q == 5'd31);
	assign quotient = quo_q;

endmodule

FILE: rtl/ghi_datapath.sv
// Datapath: state registers, multiplier, divider and output register.
`timescale 1ns / 1ps
module ghi_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [15:0]           cfg_wr_data,
	input  logic [1:0]            in_req,
	input  logic [15:0]           in_sample,
	input  logic [15:0]           in_time,
	input  ghi_pkg::ghi_cmd_t     cmd,
	output ghi_pkg::ghi_status_t  status,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [63:0]           out_data
);

	logic [15:0] cal_count_q;
	logic [15:0] rate_offset_q;
	logic [31:0] angle_acc_q;
	logic [15:0] last_time_q;
	logic [31:0] cal_sum_q;
	logic [15:0] cal_seen_q;
	logic [15:0] last_rate_q;
	logic        cal_valid_q;
	logic [1:0]  req_q;
	logic [15:0] sample_q;
	logic [15:0] time_q;
	logic [31:0] prod_q;
	logic [31:0] lo_q;
	logic [31:0] scaled_q;
	logic        neg_q;
	logic        out_valid_q;
	logic [63:0] out_data_q;

	logic [15:0] need;
	logic [15:0] seen_inc;
	logic [31:0] sum_inc;
	logic        cal_hit;
	logic [31:0] sum_mag;
	logic [15:0] rate_corr;
	logic [15:0] rate_mag;
	logic [15:0] dt;
	logic [31:0] prod_d;
	logic [59:0] lo_prod;
	logic [59:0] hi_sum;
	logic        div_load;
	logic [31:0] quotient;
	logic        div_done;
	logic [31:0] delta;
	logic [31:0] swept;
	logic signed [25:0] head_prod;
	logic [8:0]  heading;
	logic        out_free;

	// Calibration sum, count and threshold check.
	always_comb begin
		need     = (cal_count_q == 16'd0) ? 16'd1 : cal_count_q;
		seen_inc = cal_seen_q + 16'd1;
		sum_inc  = cal_sum_q + {{16{sample_q[15]}}, sample_q};
		cal_hit  = seen_inc >= need;
		sum_mag  = sum_inc[31] ? (32'd0 - sum_inc) : sum_inc;
	end

	// Corrected rate, time step and magnitude product.
	always_comb begin
		rate_corr = sample_q - rate_offset_q;
		rate_mag  = rate_corr[15] ? (16'd0 - rate_corr) : rate_corr;
		dt        = time_q - last_time_q;
		prod_d    = 32'(rate_mag * dt);
	end

	// Scaled product by the split reciprocal: low half first, then high half plus carry-in.
	always_comb begin
		lo_prod = {28'd0, prod_q} * {32'd0, ghi_pkg::SCALE_RECIP_LO};
		hi_sum  = {28'd0, prod_q} * {32'd0, ghi_pkg::SCALE_RECIP_HI} + {28'd0, lo_q};
	end

	// The divider forms the offset average when a calibrate run closes.
	assign div_load = cmd.cal_step && cal_hit;

	ghi_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.step     (cmd.div_step),
		.rem_init (25'd0),
		.dividend (sum_mag),
		.divisor  ({9'd0, seen_inc}),
		.quotient (quotient),
		.done     (div_done)
	);

	// Average and angle increment with the sign restored, truncated toward zero.
	assign delta = neg_q ? (32'd0 - quotient) : quotient;
	assign swept = neg_q ? (32'd0 - scaled_q) : scaled_q;

	// Heading in degrees from the upper half of the angle.
	always_comb begin
		head_prod = $signed(angle_acc_q[31:16]) * ghi_pkg::DEG_FULL;
		heading   = head_prod[24:16];
	end

	assign out_free = !out_valid_q || out_ready;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_count_q <= ghi_pkg::CAL_COUNT_RESET;
		end else if (cfg_wr_en) begin
			cal_count_q <= cfg_wr_data;
		end
	end

	// Captured item and intermediate products.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= in_req;
			sample_q <= in_sample;
			time_q   <= in_time;
		end
		if (cmd.upd_step) begin
			prod_q <= prod_d;
			neg_q  <= rate_corr[15];
		end else if (cmd.cal_step) begin
			neg_q <= sum_inc[31];
		end
		if (cmd.mul_lo) begin
			lo_q <= lo_prod[59:28];
		end
		if (cmd.mul_hi) begin
			scaled_q <= hi_sum[59:28];
		end
	end

	// Integrator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_offset_q <= '0;
			angle_acc_q   <= '0;
			last_time_q   <= '0;
			cal_sum_q     <= '0;
			cal_seen_q    <= '0;
			last_rate_q   <= '0;
			cal_valid_q   <= 1'b0;
		end else begin
			if (cmd.cal_step) begin
				cal_sum_q  <= cal_hit ? 32'd0 : sum_inc;
				cal_seen_q <= cal_hit ? 16'd0 : seen_inc;
			end
			if (cmd.upd_step) begin
				last_rate_q <= rate_corr;
				last_time_q <= time_q;
			end
			if (cmd.finish) begin
				case (ghi_pkg::ghi_req_t'(req_q))
					ghi_pkg::REQ_ZERO: begin
						last_time_q <= time_q;
						angle_acc_q <= '0;
					end
					ghi_pkg::REQ_CAL: begin
						rate_offset_q <= delta[15:0];
						cal_valid_q   <= 1'b1;
					end
					ghi_pkg::REQ_UPD: begin
						angle_acc_q <= angle_acc_q + swept;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Output register: holds a result until taken, frees the input side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load && out_free) begin
			out_data_q <= {6'd0, cal_valid_q, heading, angle_acc_q, last_rate_q};
		end
	end

	assign status.cal_hit  = cal_hit;
	assign status.div_done = div_done;
	assign status.out_free = out_free;
	assign out_valid       = out_valid_q;
	assign out_data        = out_data_q;

endmodule

FILE: rtl/ghi_ctrl.sv
// Controller state machine sequencing one item through the datapath.
`timescale 1ns / 1ps
module ghi_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           in_req,
	output logic                 in_ready,
	input  ghi_pkg::ghi_status_t status,
	output ghi_pkg::ghi_cmd_t    cmd
);

	ghi_pkg::ghi_state_t state_q;
	ghi_pkg::ghi_state_t state_nxt;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ghi_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ghi_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (ghi_pkg::ghi_req_t'(in_req))
						ghi_pkg::REQ_CAL: state_nxt = ghi_pkg::ST_CAL;
						ghi_pkg::REQ_UPD: state_nxt = ghi_pkg::ST_UPD;
						default:          state_nxt = ghi_pkg::ST_FIN;
					endcase
				end
			end
			ghi_pkg::ST_CAL: begin
				state_nxt = status.cal_hit ? ghi_pkg::ST_DIV : ghi_pkg::ST_OUT;
			end
			ghi_pkg::ST_UPD: state_nxt = ghi_pkg::ST_MLO;
			ghi_pkg::ST_MLO: state_nxt = ghi_pkg::ST_MHI;
			ghi_pkg::ST_MHI: state_nxt = ghi_pkg::ST_FIN;
			ghi_pkg::ST_DIV: begin
				if (status.div_done) begin
					state_nxt = ghi_pkg::ST_FIN;
				end
			end
			ghi_pkg::ST_FIN:  state_nxt = ghi_pkg::ST_OUT;
			ghi_pkg::ST_OUT: begin
				if (status.out_free) begin
					state_nxt = ghi_pkg::ST_IDLE;
				end
			end
			default: state_nxt = ghi_pkg::ST_IDLE;
		endcase
	end

	// Commands per state.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ghi_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ghi_pkg::ST_CAL: cmd.cal_step = 1'b1;
			ghi_pkg::ST_UPD: cmd.upd_step = 1'b1;
			ghi_pkg::ST_MLO: cmd.mul_lo   = 1'b1;
			ghi_pkg::ST_MHI: cmd.mul_hi   = 1'b1;
			ghi_pkg::ST_DIV: cmd.div_step = 1'b1;
			ghi_pkg::ST_FIN: cmd.finish   = 1'b1;
			ghi_pkg::ST_OUT: cmd.out_load = 1'b1;
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/gyro_heading_integrator.sv
// Top level of the gyro heading integrator.
// One item at a time. An update item runs the update, low and high multiply, finish and
// output states; a calibrate item closing a run runs calibrate, divide, finish and output;
// other calibrate items run calibrate and output, and zero or none items finish and output.
// The next item is accepted while a result still waits in the output register.
// Reset (arst_n, async): controller and integrator clear; calibration_count back to 5120.
`timescale 1ns / 1ps
module gyro_heading_integrator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,  // calibration_count
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,      // rate_sample[15:0], time_us[31:16]
	input  logic [1:0]  s_tuser,      // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// turn_rate[15:0], turn_angle[47:16], heading_deg[56:48], calibrated[57], zero[63:58]
	output logic [63:0] m_tdata
);

	ghi_pkg::ghi_cmd_t    cmd;
	ghi_pkg::ghi_status_t status;

	ghi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_req   (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ghi_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_req      (s_tuser),
		.in_sample   (s_tdata[15:0]),
		.in_time     (s_tdata[31:16]),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_data    (m_tdata)
	);

`ifndef SYNTHESIS
	// One item in flight: no new item right after an acceptance.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while another was in progress");

	// A result appears only after the controller asked for it.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("result shown without an output load");

	// The last divider step is followed by the finish step.
	a_div_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && status.div_done |=> cmd.finish)
		else $error("divider finished without a finish step");
`endif

endmodule
